// ===== rtl/llrb_pkg.sv =====
`timescale 1ns / 1ps
package llrb_pkg;
    localparam int RING_SIZE    = 32768;
    localparam int MAX_LINES    = 256;
    localparam int MAX_LINE_LEN = 240;
    localparam int RING_AW      = $clog2(RING_SIZE);
    localparam int SLOT_W       = $clog2(MAX_LINES);
    localparam int CNT_W        = $clog2(MAX_LINES + 1);
    localparam int PEND_AW      = $clog2(MAX_LINE_LEN);
    localparam int HELD_W       = $clog2(RING_SIZE + 1);
    localparam logic [7:0] NEWLINE_BYTE = 8'd10;
    localparam int QDEPTH = 2;

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] char_in;
        logic [8:0] lines_wanted;
        logic [7:0] line_offset;
        logic [7:0] byte_offset;
    } t_item;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        read_valid;
        logic [7:0]  line_length;
        logic [8:0]  lines_selected;
        logic [8:0]  line_total;
        logic [15:0] bytes_held;
        logic        line_committed;
    } t_result;
endpackage

// ===== rtl/llrb_fifo.sv =====
`timescale 1ns / 1ps
// Small register queue; used between front and back and on the result side.
module llrb_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    logic [WIDTH-1:0] r_mem [llrb_pkg::QDEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic w_push, w_pop;

    assign o_full  = (r_cnt == 2'(llrb_pkg::QDEPTH));
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule

// ===== rtl/llrb_front.sv =====
`timescale 1ns / 1ps
// Front: takes items from the port and queues them for the engine.
module llrb_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  llrb_pkg::t_item     i_item,
    output logic                o_full,
    input  logic                i_take,
    output llrb_pkg::t_item     o_item,
    output logic                o_avail
);
    logic w_empty;

    llrb_fifo #(.WIDTH($bits(llrb_pkg::t_item))) u_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (i_item),
        .o_full  (o_full),
        .i_pop   (i_take),
        .o_data  (o_item),
        .o_empty (w_empty)
    );
    assign o_avail = !w_empty;
endmodule

// ===== rtl/llrb_engine.sv =====
`timescale 1ns / 1ps
// Back: executes append, commit and read against the line index and ring.
module llrb_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_avail,
    input  llrb_pkg::t_item     i_item,
    output logic                o_take,
    output logic                o_res_valid,
    output llrb_pkg::t_result   o_res,
    input  logic                i_res_full
);
    localparam int RAW = llrb_pkg::RING_AW;
    localparam int SW  = llrb_pkg::SLOT_W;
    localparam int CW  = llrb_pkg::CNT_W;
    localparam int PW  = llrb_pkg::PEND_AW;
    localparam int HW  = llrb_pkg::HELD_W;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_EVICT = 10'b0000000010,
        S_EVRD  = 10'b0000000100,
        S_PRD   = 10'b0000001000,
        S_COPY  = 10'b0000010000,
        S_RSLOT = 10'b0000100000,
        S_RLEN  = 10'b0001000000,
        S_RRING = 10'b0010000000,
        S_RDAT  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state r_state;
    llrb_pkg::t_item r_item;

    logic [7:0]      r_ring [llrb_pkg::RING_SIZE];
    logic [RAW-1:0]  r_start [llrb_pkg::MAX_LINES];
    logic [7:0]      r_len [llrb_pkg::MAX_LINES];
    logic [7:0]      r_pend [llrb_pkg::MAX_LINE_LEN];

    logic [SW-1:0]   r_oldest;
    logic [CW-1:0]   r_count;
    logic [HW-1:0]   r_held;
    logic [RAW-1:0]  r_wpos;
    logic [7:0]      r_plen;
    logic [7:0]      r_ci;

    logic [7:0]      r_len_q;
    logic [RAW-1:0]  r_start_q;
    logic [7:0]      r_pend_q;
    logic [7:0]      r_ring_q;
    logic [SW-1:0]   r_slot;
    logic [CW-1:0]   r_sel;
    logic            r_lok;
    llrb_pkg::t_result r_res;

    logic [HW:0]     w_need_sum;
    logic [CW-1:0]   w_first;
    logic [CW-1:0]   w_sel;

    assign w_need_sum = (HW+1)'(r_held) + (HW+1)'(r_plen) + (HW+1)'(1);
    assign w_first = (r_item.lines_wanted != 9'd0 && CW'(r_item.lines_wanted) < r_count)
                     ? r_count - CW'(r_item.lines_wanted) : '0;
    assign w_sel = r_count - w_first;

    assign o_take      = (r_state == S_IDLE) && i_avail;
    assign o_res_valid = (r_state == S_OUT) && !i_res_full;

    // counts are final by S_OUT, so they go out straight from the registers
    always_comb begin
        o_res            = r_res;
        o_res.line_total = 9'(r_count);
        o_res.bytes_held = 16'(r_held);
    end

    // memory ports
    always_ff @(posedge i_clk) begin
        r_len_q   <= r_len[(r_state == S_EVICT) ? r_oldest : r_slot];
        r_start_q <= r_start[r_slot];
        r_pend_q  <= r_pend[r_ci[PW-1:0]];
        r_ring_q  <= r_ring[RAW'(r_start_q + RAW'(r_item.byte_offset))];
        if (r_state == S_IDLE && o_take && i_item.cmd == llrb_pkg::CMD_APPEND
            && i_item.char_in != llrb_pkg::NEWLINE_BYTE
            && r_plen < 8'(llrb_pkg::MAX_LINE_LEN)) begin
            r_pend[r_plen[PW-1:0]] <= i_item.char_in;
        end
        if (r_state == S_COPY) begin
            r_ring[RAW'(r_wpos + RAW'(r_ci))] <=
                (r_ci == r_plen) ? llrb_pkg::NEWLINE_BYTE : r_pend_q;
        end
        if (r_state == S_COPY && r_ci == r_plen) begin
            r_start[r_slot] <= r_wpos;
            r_len[r_slot]   <= r_plen + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_oldest <= '0;
            r_count  <= '0;
            r_held   <= '0;
            r_wpos   <= '0;
            r_plen   <= '0;
        end else begin
            case (r_state)
                S_IDLE: if (i_avail) begin
                    r_item <= i_item;
                    r_res  <= '0;
                    if (i_item.cmd == llrb_pkg::CMD_READ) begin
                        r_state <= S_RSLOT;
                    end else if (i_item.char_in == llrb_pkg::NEWLINE_BYTE) begin
                        r_state <= S_EVICT;
                    end else begin
                        if (r_plen < 8'(llrb_pkg::MAX_LINE_LEN)) r_plen <= r_plen + 8'd1;
                        r_state <= S_OUT;
                    end
                end
                // decide one eviction per pass; length read issued this cycle
                S_EVICT: begin
                    if ((r_count != '0 && w_need_sum > (HW+1)'(llrb_pkg::RING_SIZE))
                        || r_count >= CW'(llrb_pkg::MAX_LINES)) begin
                        r_state <= S_EVRD;
                    end else begin
                        r_slot  <= SW'(r_oldest + SW'(r_count));
                        r_ci    <= '0;
                        r_state <= S_PRD;
                    end
                end
                S_EVRD: begin
                    r_held   <= r_held - HW'(r_len_q);
                    r_oldest <= r_oldest + SW'(1);
                    r_count  <= r_count - CW'(1);
                    r_state  <= S_EVICT;
                end
                S_PRD: r_state <= S_COPY;  // pending read latency
                S_COPY: begin
                    if (r_ci == r_plen) begin
                        r_wpos  <= RAW'(r_wpos + RAW'(r_plen) + RAW'(1));
                        r_count <= r_count + CW'(1);
                        r_held  <= r_held + HW'(r_plen) + HW'(1);
                        r_plen  <= '0;
                        r_res.line_committed <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_ci    <= r_ci + 8'd1;
                        r_state <= S_PRD;
                    end
                end
                S_RSLOT: begin
                    r_sel   <= w_sel;
                    r_lok   <= CW'(r_item.line_offset) < w_sel;
                    r_slot  <= SW'(r_oldest + SW'(w_first) + SW'(r_item.line_offset));
                    r_state <= S_RLEN;
                end
                S_RLEN:  r_state <= S_RRING;  // len/start registered
                S_RRING: r_state <= S_RDAT;   // ring byte registered
                S_RDAT:  r_state <= S_OUT;
                S_OUT: if (!i_res_full) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_RDAT) begin
                r_res.lines_selected <= 9'(r_sel);
                if (r_lok) begin
                    r_res.line_length <= r_len_q;
                    if (r_item.byte_offset < r_len_q) begin
                        r_res.read_valid <= 1'b1;
                        r_res.data_byte  <= r_ring_q;
                    end
                end
            end
        end
    end

    // ring byte read needs start registered first: S_RLEN, then S_RRING gives it
endmodule

// ===== rtl/line_log_ring_buffer_core.sv =====
`timescale 1ns / 1ps
// Line log ring buffer. Append items (cmd 0) feed log bytes into a pending line
// of at most 240 bytes; a newline commits the line plus newline into a 32 KiB
// byte ring, evicting oldest lines until it fits (and once more if the 256-entry
// line index is full). Read items (cmd 1) return one byte addressed by line and
// byte offset within the newest lines_wanted lines. Both sides are queues: push/
// full in, empty/pop out. A plain append goes from idle straight to its result; a
// read steps through slot, length/start, ring byte and capture, each registered; a
// commit checks and reads one evicted line per pass, then copies one byte per
// pass (newline included), since the single-port pending buffer feeds the ring
// write. No clearing pass after reset.
module line_log_ring_buffer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_cmd,
    input  logic [7:0]  i_char_in,
    input  logic [8:0]  i_lines_wanted,
    input  logic [7:0]  i_line_offset,
    input  logic [7:0]  i_byte_offset,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_data_byte,
    output logic        o_read_valid,
    output logic [7:0]  o_line_length,
    output logic [8:0]  o_lines_selected,
    output logic [8:0]  o_line_total,
    output logic [15:0] o_bytes_held,
    output logic        o_line_committed
);
    llrb_pkg::t_item   w_in, w_item;
    llrb_pkg::t_result w_res, w_out;
    logic w_avail, w_take, w_res_valid, w_res_full;

    assign w_in = '{cmd: i_cmd, char_in: i_char_in, lines_wanted: i_lines_wanted,
                    line_offset: i_line_offset, byte_offset: i_byte_offset};

    llrb_front u_front (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_push (push), .i_item (w_in),
        .o_full (full), .i_take (w_take), .o_item (w_item), .o_avail (w_avail)
    );

    llrb_engine u_engine (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_avail (w_avail), .i_item (w_item),
        .o_take (w_take), .o_res_valid (w_res_valid), .o_res (w_res),
        .i_res_full (w_res_full)
    );

    // result queue: the engine moves on while a result waits for its transfer
    llrb_fifo #(.WIDTH($bits(llrb_pkg::t_result))) u_outq (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_push (w_res_valid), .i_data (w_res),
        .o_full (w_res_full), .i_pop (pop), .o_data (w_out), .o_empty (empty)
    );

    assign o_data_byte      = w_out.data_byte;
    assign o_read_valid     = w_out.read_valid;
    assign o_line_length    = w_out.line_length;
    assign o_lines_selected = w_out.lines_selected;
    assign o_line_total     = w_out.line_total;
    assign o_bytes_held     = w_out.bytes_held;
    assign o_line_committed = w_out.line_committed;
endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;

    // Golden model of the line store plus the list of results still owed
    class line_log_scoreboard;
        llrb_pkg::t_result owed_q[$];
        logic [7:0]  ring_mem[llrb_pkg::RING_SIZE];
        int          line_start[llrb_pkg::MAX_LINES];
        int          line_len[llrb_pkg::MAX_LINES];
        logic [7:0]  pend_mem[llrb_pkg::MAX_LINE_LEN];
        int          oldest;
        int          line_cnt;
        int          held;
        int          wr_pos;
        int          pend_len;

        function new();
            oldest   = 0;
            line_cnt = 0;
            held     = 0;
            wr_pos   = 0;
            pend_len = 0;
        endfunction

        function void evict_oldest();
            held     -= line_len[oldest];
            oldest    = (oldest + 1) % llrb_pkg::MAX_LINES;
            line_cnt -= 1;
        endfunction

        // Newline: evict until the line fits, then once more if the index is full
        function void commit_line();
            int need;
            int slot;
            need = pend_len + 1;
            while (line_cnt > 0 && held + need > llrb_pkg::RING_SIZE)
                evict_oldest();
            if (line_cnt >= llrb_pkg::MAX_LINES)
                evict_oldest();
            slot = (oldest + line_cnt) % llrb_pkg::MAX_LINES;
            line_start[slot] = wr_pos;
            line_len[slot]   = need;
            for (int i = 0; i < pend_len; i++)
                ring_mem[(wr_pos + i) % llrb_pkg::RING_SIZE] = pend_mem[i];
            ring_mem[(wr_pos + pend_len) % llrb_pkg::RING_SIZE] = llrb_pkg::NEWLINE_BYTE;
            wr_pos    = (wr_pos + need) % llrb_pkg::RING_SIZE;
            line_cnt += 1;
            held     += need;
            pend_len  = 0;
        endfunction

        // Called once per accepted input transfer
        function void note_item(llrb_pkg::t_item it);
            llrb_pkg::t_result r;
            int first;
            int sel;
            int slot;
            r = '0;
            if (it.cmd == llrb_pkg::CMD_APPEND) begin
                if (it.char_in == llrb_pkg::NEWLINE_BYTE) begin
                    commit_line();
                    r.line_committed = 1'b1;
                end else if (pend_len < llrb_pkg::MAX_LINE_LEN) begin
                    pend_mem[pend_len] = it.char_in;
                    pend_len += 1;
                end
            end else if (line_cnt > 0) begin
                first = 0;
                if (it.lines_wanted > 0 && it.lines_wanted < line_cnt)
                    first = line_cnt - it.lines_wanted;
                sel = line_cnt - first;
                r.lines_selected = sel[8:0];
                if (it.line_offset < sel) begin
                    slot = (oldest + first + it.line_offset) % llrb_pkg::MAX_LINES;
                    r.line_length = line_len[slot][7:0];
                    if (it.byte_offset < line_len[slot]) begin
                        r.data_byte  = ring_mem[(line_start[slot] + it.byte_offset)
                                                % llrb_pkg::RING_SIZE];
                        r.read_valid = 1'b1;
                    end
                end
            end
            r.line_total = line_cnt[8:0];
            r.bytes_held = held[15:0];
            owed_q.push_back(r);
        endfunction

        // Returns an empty string on a match, else a description of the first bad field
        function string check_result(llrb_pkg::t_result got);
            llrb_pkg::t_result e;
            if (owed_q.size() == 0)
                return "result with no expectation waiting";
            e = owed_q.pop_front();
            if (got.data_byte !== e.data_byte)
                return $sformatf("data_byte %0d exp %0d", got.data_byte, e.data_byte);
            if (got.read_valid !== e.read_valid)
                return $sformatf("read_valid %0b exp %0b", got.read_valid, e.read_valid);
            if (got.line_length !== e.line_length)
                return $sformatf("line_length %0d exp %0d", got.line_length, e.line_length);
            if (got.lines_selected !== e.lines_selected)
                return $sformatf("lines_selected %0d exp %0d",
                                 got.lines_selected, e.lines_selected);
            if (got.line_total !== e.line_total)
                return $sformatf("line_total %0d exp %0d", got.line_total, e.line_total);
            if (got.bytes_held !== e.bytes_held)
                return $sformatf("bytes_held %0d exp %0d", got.bytes_held, e.bytes_held);
            if (got.line_committed !== e.line_committed)
                return $sformatf("line_committed %0b exp %0b",
                                 got.line_committed, e.line_committed);
            return "";
        endfunction

        function int owed();
            return owed_q.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        i_cmd = llrb_pkg::CMD_APPEND;
    logic [7:0]  i_char_in = '0;
    logic [8:0]  i_lines_wanted = '0;
    logic [7:0]  i_line_offset = '0;
    logic [7:0]  i_byte_offset = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  o_data_byte;
    logic        o_read_valid;
    logic [7:0]  o_line_length;
    logic [8:0]  o_lines_selected;
    logic [8:0]  o_line_total;
    logic [15:0] o_bytes_held;
    logic        o_line_committed;

    line_log_scoreboard store_sb = new();
    int  fail_count = 0;
    int  send_idle_pct = 9;    // sender gap chance per cycle, percent
    int  recv_idle_pct = 52;   // receiver stall chance per cycle, percent
    bit  stall_req = 1'b0;     // asks the receiver for one long hold-off
    int  stall_left = 0;

    line_log_ring_buffer_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_cmd           (i_cmd),
        .i_char_in       (i_char_in),
        .i_lines_wanted  (i_lines_wanted),
        .i_line_offset   (i_line_offset),
        .i_byte_offset   (i_byte_offset),
        .empty           (empty),
        .pop             (pop),
        .o_data_byte     (o_data_byte),
        .o_read_valid    (o_read_valid),
        .o_line_length   (o_line_length),
        .o_lines_selected(o_lines_selected),
        .o_line_total    (o_line_total),
        .o_bytes_held    (o_bytes_held),
        .o_line_committed(o_line_committed)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    // One input transfer. Optional random gap first; push stays high across
    // back-to-back items so it gets a single nonblocking write per step.
    task automatic send_item(llrb_pkg::t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push           <= 1'b1;
        i_cmd          <= it.cmd;
        i_char_in      <= it.char_in;
        i_lines_wanted <= it.lines_wanted;
        i_line_offset  <= it.line_offset;
        i_byte_offset  <= it.byte_offset;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        // push high and full low before this edge: transfer taken
        store_sb.note_item(it);
    endtask

    task automatic append_byte(logic [7:0] ch);
        llrb_pkg::t_item it;
        it         = '0;
        it.cmd     = llrb_pkg::CMD_APPEND;
        it.char_in = ch;
        it.lines_wanted = 9'($urandom);    // ignored on append, toggled anyway
        it.line_offset  = 8'($urandom);
        it.byte_offset  = 8'($urandom);
        send_item(it);
    endtask

    task automatic read_byte(int wanted, int line_off, int byte_off);
        llrb_pkg::t_item it;
        it              = '0;
        it.cmd          = llrb_pkg::CMD_READ;
        it.char_in      = 8'($urandom);
        it.lines_wanted = wanted[8:0];
        it.line_offset  = line_off[7:0];
        it.byte_offset  = byte_off[7:0];
        send_item(it);
    endtask

    // Well-formed line: content without newlines, then the newline
    task automatic append_line(int len);
        logic [7:0] ch;
        for (int i = 0; i < len; i++) begin
            ch = 8'($urandom);
            if (ch == llrb_pkg::NEWLINE_BYTE)
                ch = 8'hFF;
            append_byte(ch);
        end
        append_byte(llrb_pkg::NEWLINE_BYTE);
    endtask

    // Read aimed at stored lines, mostly in range
    task automatic read_aimed();
        int wanted;
        int line_off;
        int byte_off;
        wanted   = ($urandom_range(3) == 0) ? 0 : $urandom_range(store_sb.line_cnt + 2);
        line_off = $urandom_range((store_sb.line_cnt > 0) ? store_sb.line_cnt : 1);
        if (wanted > 0 && wanted < store_sb.line_cnt)
            line_off = $urandom_range(wanted);
        byte_off = ($urandom_range(4) == 0) ? $urandom_range(255) : $urandom_range(30);
        read_byte(wanted, line_off, byte_off);
    endtask

    // Pause the sender until every owed result has come back
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (store_sb.owed() > 0)
            @(posedge i_clk);
    endtask

    // Random mix: mostly whole lines with reads between, some raw noise
    task automatic random_traffic(int n_items);
        int done;
        int before_cnt;
        llrb_pkg::t_item it;
        done = 0;
        while (done < n_items) begin
            case ($urandom_range(9))
                0: begin
                    it = llrb_pkg::t_item'($bits(llrb_pkg::t_item)'({$urandom, $urandom}));
                    send_item(it);
                    done++;
                end
                1, 2, 3: begin
                    read_aimed();
                    done++;
                end
                default: begin
                    before_cnt = $urandom_range(19);
                    if ($urandom_range(15) == 0)
                        before_cnt = $urandom_range(llrb_pkg::MAX_LINE_LEN + 10);
                    append_line(before_cnt);
                    done += before_cnt + 1;
                end
            endcase
        end
    endtask

    // Receiver: check at each edge where a result transfer happens, then pick
    // the next pop. Long hold-offs are counted here.
    initial begin
        string msg;
        llrb_pkg::t_result got;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                got = {o_data_byte, o_read_valid, o_line_length, o_lines_selected,
                       o_line_total, o_bytes_held, o_line_committed};
                msg = store_sb.check_result(got);
                if (msg != "")
                    report_mismatch(msg);
            end
            if (stall_req) begin
                stall_req  = 1'b0;
                stall_left = 400;
            end
            if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Sender and run control
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty store, byte extremes, empty line, offset edges
        read_byte(0, 0, 0);
        append_byte(8'h00);
        append_byte(8'hFF);
        append_byte(8'h41);
        append_byte(llrb_pkg::NEWLINE_BYTE);
        append_byte(llrb_pkg::NEWLINE_BYTE);  // empty line
        append_byte(8'h7E);
        append_byte(llrb_pkg::NEWLINE_BYTE);
        read_byte(0, 0, 0);
        read_byte(0, 0, 3);                   // newline of first line
        read_byte(0, 0, 4);                   // byte past line end
        read_byte(0, 0, 255);
        read_byte(0, 1, 0);
        read_byte(0, 3, 0);                   // line past selection
        read_byte(0, 255, 0);
        read_byte(1, 0, 0);                   // newest line only
        read_byte(2, 1, 1);
        read_byte(3, 2, 1);                   // wanted equals count
        read_byte(256, 0, 2);
        read_byte(511, 2, 0);
        read_byte(1, 1, 0);
        append_byte(8'h55);                   // pending, not yet visible
        read_byte(0, 2, 1);
        append_byte(llrb_pkg::NEWLINE_BYTE);
        read_byte(0, 3, 1);

        // Phase 1: slow receiver; one long hold-off while items keep coming
        random_traffic(200);
        stall_req = 1'b1;
        random_traffic(200);
        wait_drained();

        // Phase 2: slow sender, quick receiver
        send_idle_pct = 52;
        recv_idle_pct = 9;
        random_traffic(300);
        wait_drained();

        // Phase 3: no idling; fill the line index, then overlong lines
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_traffic(200);
        for (int i = 0; i < 270; i++)
            append_byte(llrb_pkg::NEWLINE_BYTE);
        repeat (8) read_aimed();
        read_byte(0, 255, 0);
        for (int i = 0; i < 2; i++) begin
            append_line(llrb_pkg::MAX_LINE_LEN + 8);
            read_aimed();
        end
        random_traffic(50);

        push <= 1'b0;
        @(posedge i_clk);
        while (store_sb.owed() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (store_sb.owed() > 0)
            report_mismatch($sformatf("%0d expected results never came", store_sb.owed()));
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #30ms;
        $display("%0t timeout", $realtime);
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
